// ----- rtl/eesh_pkg.sv -----
// ----------------------------------------------------------------------------
// eesh_pkg
// Types and constants for the thresholded event energy-sum histogram.
// ----------------------------------------------------------------------------
package eesh_pkg;

    localparam int NUM_BINS     = 512;
    localparam int MAX_CHANNELS = 1024;

    localparam int AMP_W   = 12;
    localparam int IDX_W   = 10;
    localparam int SUM_W   = 22;
    localparam int COUNT_W = 32;
    localparam int THR_W   = 12;
    localparam int CH_W    = 11;
    localparam int CFG_W   = 22;
    localparam int CFG_A_W = 2;

    // histogram store, overflow bin included
    localparam int DEPTH  = NUM_BINS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    // quotient bits of floor(sum * NUM_BINS / range_top)
    localparam int QUO_W  = $clog2(NUM_BINS);
    localparam int NUM_W  = SUM_W + ADDR_W;
    localparam int CHC_W  = $clog2(MAX_CHANNELS);

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_READ    = 1'b1;
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CFG_A_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_CHANNELS  = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_RANGE_TOP = 2'd2;

    localparam logic [THR_W-1:0] THRESHOLD_RST = 12'd50;
    localparam logic [CH_W-1:0]  CHANNELS_RST  = 11'd64;
    localparam logic [CFG_W-1:0] RANGE_TOP_RST = 22'd20000;

    typedef struct packed {
        logic             op;
        logic [AMP_W-1:0] amplitude;
        logic [IDX_W-1:0] bin_index;
    } t_in;

    typedef struct packed {
        logic               kind;
        logic [SUM_W-1:0]   event_sum;
        logic [IDX_W-1:0]   event_bin;
        logic [COUNT_W-1:0] bin_count;
    } t_out;

endpackage

// ----- rtl/event_energy_sum_histogram.sv -----
// ----------------------------------------------------------------------------
// event_energy_sum_histogram
// Sums thresholded channel amplitudes per trigger event, bins the sum by a
// bit-serial divider and counts it in a histogram memory (one read, one write port).
// ----------------------------------------------------------------------------
// Flow: a sample that does not close an event is accumulated, and the block stays
// ready; a bin read goes through S_RD to S_EMIT; a closing sample takes 9 quotient
// steps, one per cycle, then bin read, update, output; an overflow skips the steps.
// One beat at a time: the next beat is taken the cycle after the result is
// registered, later while the receiver holds off.
// Reset: configuration returns to defaults, then a clearing pass writes zero
// to all 513 histogram entries before the first beat is taken.
module event_energy_sum_histogram
    import eesh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_BINRD = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_RD    = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam logic [ADDR_W-1:0]  OVF_BIN = ADDR_W'(NUM_BINS);
    localparam logic [SUM_W-1:0]   SUM_MAX = '1;
    localparam logic [COUNT_W-1:0] CNT_MAX = '1;
    localparam logic [3:0]         DIV_LAST = 4'(QUO_W - 1);

    logic [2:0]         r_state;
    logic [THR_W-1:0]   r_threshold;
    logic [CH_W-1:0]    r_channels;
    logic [CFG_W-1:0]   r_range_top;
    logic [SUM_W-1:0]   r_sum;
    logic [CHC_W-1:0]   r_chan_cnt;
    logic [ADDR_W-1:0]  r_clr;
    logic [SUM_W-1:0]   r_ev_sum;
    logic [ADDR_W-1:0]  r_bin;
    logic [SUM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_num_lo;
    logic [QUO_W-1:0]   r_quo;
    logic [3:0]         r_div_cnt;
    t_out               r_res;
    t_out               r_out;
    logic               r_out_valid;

    // histogram memory
    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_rdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COUNT_W-1:0] mem_wdata;

    logic               in_acc;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   n_sum;
    logic [CH_W-1:0]    eff_chan;
    logic [CH_W-1:0]    n_chan_cnt;
    logic               ev_end;
    logic [NUM_W-1:0]   num;
    logic [SUM_W:0]     trial;
    logic               trial_ge;
    logic [QUO_W-1:0]   n_quo;
    logic               out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        sum_add = {1'b0, r_sum} + (SUM_W + 1)'(i_in.amplitude);
        if (i_in.amplitude >= r_threshold) begin
            n_sum = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        end else begin
            n_sum = r_sum;
        end
        if (r_channels == '0) begin
            eff_chan = CH_W'(1);
        end else if (r_channels > CH_W'(MAX_CHANNELS)) begin
            eff_chan = CH_W'(MAX_CHANNELS);
        end else begin
            eff_chan = r_channels;
        end
        n_chan_cnt = CH_W'(r_chan_cnt) + CH_W'(1);
        ev_end     = (n_chan_cnt >= eff_chan);
        num        = NUM_W'(n_sum) * NUM_W'(NUM_BINS);
    end

    // one restoring-division step per cycle
    always_comb begin
        trial    = {r_rem, r_num_lo[QUO_W-1]};
        trial_ge = (trial >= {1'b0, r_range_top});
        n_quo    = {r_quo[QUO_W-2:0], trial_ge};
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_bin;
        mem_we    = 1'b0;
        mem_waddr = r_bin;
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_IDLE: begin
                if (in_acc && i_in.op == OP_READ && i_in.bin_index <= IDX_W'(NUM_BINS)) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(i_in.bin_index);
                end
            end
            S_BINRD: begin
                mem_re = 1'b1;
            end
            S_UPD: begin
                mem_we    = 1'b1;
                mem_wdata = (r_rdata == CNT_MAX) ? r_rdata : r_rdata + COUNT_W'(1);
            end
            S_DIV, S_RD, S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_threshold <= THRESHOLD_RST;
            r_channels  <= CHANNELS_RST;
            r_range_top <= RANGE_TOP_RST;
            r_sum       <= '0;
            r_chan_cnt  <= '0;
            r_clr       <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    CFG_CHANNELS:  r_channels  <= i_cfg_data[CH_W-1:0];
                    CFG_RANGE_TOP: r_range_top <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr == OVF_BIN) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + ADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.op == OP_READ) begin
                            r_res <= '{kind: KIND_READ, event_sum: '0, event_bin: '0,
                                       bin_count: '0};
                            if (i_in.bin_index <= IDX_W'(NUM_BINS)) begin
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end else if (ev_end) begin
                            r_ev_sum   <= n_sum;
                            r_sum      <= '0;
                            r_chan_cnt <= '0;
                            if (n_sum >= r_range_top) begin
                                r_bin   <= OVF_BIN;
                                r_state <= S_BINRD;
                            end else begin
                                // quotient fits QUO_W bits, so the top part is below the divisor
                                r_rem     <= num[QUO_W +: SUM_W];
                                r_num_lo  <= num[QUO_W-1:0];
                                r_quo     <= '0;
                                r_div_cnt <= '0;
                                r_state   <= S_DIV;
                            end
                        end else begin
                            r_sum      <= n_sum;
                            r_chan_cnt <= n_chan_cnt[CHC_W-1:0];
                        end
                    end
                end
                S_DIV: begin
                    r_rem     <= trial_ge ? SUM_W'(trial - {1'b0, r_range_top})
                                          : trial[SUM_W-1:0];
                    r_num_lo  <= r_num_lo << 1;
                    r_quo     <= n_quo;
                    r_div_cnt <= r_div_cnt + 4'd1;
                    if (r_div_cnt == DIV_LAST) begin
                        r_bin   <= ADDR_W'(n_quo);
                        r_state <= S_BINRD;
                    end
                end
                S_BINRD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_res   <= '{kind: KIND_EVENT, event_sum: r_ev_sum,
                                 event_bin: IDX_W'(r_bin), bin_count: '0};
                    r_state <= S_EMIT;
                end
                S_RD: begin
                    r_res.bin_count <= r_rdata;
                    r_state         <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no beat taken while the histogram is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("beat accepted during clearing pass");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_cnt <= DIV_LAST))
        else $error("divider ran past its last step");

    a_event_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.kind == KIND_EVENT) |-> (o_out.event_bin <= IDX_W'(NUM_BINS)))
        else $error("event bin beyond overflow bin");

    a_update_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> ($past(r_state) == S_BINRD))
        else $error("histogram update without its read");

endmodule

// ----- verif/tb_event_energy_sum_histogram.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_event_energy_sum_histogram
// Self-checking bench for the event energy-sum histogram. A scoreboard class
// keeps its own copy of the registers, the running event sum and all 513 bin
// counts, works out the result owed by every accepted input beat and checks
// the output beats against it in order. Stimulus: reset defaults, a directed
// run over the edge cases, one full-size event, then randomised phases with
// varied register settings and sender/receiver throttling.
// ----------------------------------------------------------------------------
module tb_event_energy_sum_histogram;
    import eesh_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_BEATS    = 16;
    localparam int AMP_MAX        = (1 << AMP_W) - 1;
    localparam int unsigned SUM_LIMIT = (1 << SUM_W) - 1;
    // index with no register behind it
    localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

    class hist_scoreboard;
        logic [THR_W-1:0]   thr;
        logic [CH_W-1:0]    chans;
        logic [CFG_W-1:0]   rtop;
        int unsigned        acc_sum;
        int unsigned        chan_seen;
        logic [COUNT_W-1:0] counts [DEPTH];
        t_out               due_results [$];
        int                 errors;

        function new();
            thr       = THRESHOLD_RST;
            chans     = CHANNELS_RST;
            rtop      = RANGE_TOP_RST;
            acc_sum   = 0;
            chan_seen = 0;
            errors    = 0;
            foreach (counts[i]) counts[i] = '0;
        endfunction

        function void configure(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRESHOLD: thr   = data[THR_W-1:0];
                CFG_CHANNELS:  chans = data[CH_W-1:0];
                CFG_RANGE_TOP: rtop  = data;
                default: ;
            endcase
        endfunction

        function void absorb_beat(t_in x);
            t_out              e;
            int unsigned       eff;
            longint unsigned   q;
            logic [ADDR_W-1:0] b;
            e = '0;
            if (x.op == OP_READ) begin
                e.kind = KIND_READ;
                if (x.bin_index <= IDX_W'(NUM_BINS)) e.bin_count = counts[x.bin_index];
                due_results.push_back(e);
                return;
            end
            if (x.amplitude >= thr) begin
                acc_sum = acc_sum + 32'(x.amplitude);
                if (acc_sum > SUM_LIMIT) acc_sum = SUM_LIMIT;
            end
            chan_seen++;
            eff = 32'(chans);
            if (eff == 0) eff = 1;
            if (eff > MAX_CHANNELS) eff = MAX_CHANNELS;
            if (chan_seen >= eff) begin
                // range_top of zero falls through to overflow, no divide
                if (acc_sum >= 32'(rtop)) begin
                    b = ADDR_W'(NUM_BINS);
                end else begin
                    q = (64'(acc_sum) * 64'(NUM_BINS)) / 64'(rtop);
                    b = q[ADDR_W-1:0];
                end
                if (counts[b] != '1) counts[b] = counts[b] + COUNT_W'(1);
                e.kind      = KIND_EVENT;
                e.event_sum = acc_sum[SUM_W-1:0];
                e.event_bin = b;
                due_results.push_back(e);
                acc_sum   = 0;
                chan_seen = 0;
            end
        endfunction

        function void match_result(t_out got);
            t_out e;
            if (due_results.size() == 0) begin
                $display("%0t unexpected result beat: kind %0d sum %0d bin %0d count %0d",
                         $time, got.kind, got.event_sum, got.event_bin, got.bin_count);
                errors++;
                return;
            end
            e = due_results.pop_front();
            if (got.kind !== e.kind || got.event_sum !== e.event_sum ||
                got.event_bin !== e.event_bin || got.bin_count !== e.bin_count) begin
                $display("%0t result mismatch: expected kind %0d sum %0d bin %0d count %0d",
                         $time, e.kind, e.event_sum, e.event_bin, e.bin_count);
                $display("%0t                  actual   kind %0d sum %0d bin %0d count %0d",
                         $time, got.kind, got.event_sum, got.event_bin, got.bin_count);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_A_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in                i_in;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out               o_out;

    hist_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    // bumped once per requested long hold-off
    int long_hold_seq;
    int quiet_cycles = 0;

    event_energy_sum_histogram uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off when asked for
    initial begin
        int hold_left;
        int hold_seen;
        hold_left   = 0;
        hold_seen   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_seq != hold_seen) begin
                hold_left = LONG_HOLD;
                hold_seen = long_hold_seq;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.match_result(o_out);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void set_mode(int m);
        case (m)
            1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
            3:       begin send_idle_pct = 29; recv_stall_pct = 29; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endfunction

    function automatic t_in beat(logic op, logic [AMP_W-1:0] a, logic [IDX_W-1:0] idx);
        t_in x;
        x.op        = op;
        x.amplitude = a;
        x.bin_index = idx;
        return x;
    endfunction

    function automatic t_in random_beat();
        t_in x;
        int  a;
        int  r;
        x.op = ($urandom_range(0, 99) < 25) ? OP_READ : OP_SAMPLE;
        if ($urandom_range(0, 1) == 1) begin
            x.amplitude = AMP_W'($urandom);
        end else begin
            // cluster around the threshold to hit the >= edge
            a = int'(sb.thr) + int'($urandom_range(0, 6)) - 3;
            if (a < 0) a = 0;
            if (a > AMP_MAX) a = AMP_MAX;
            x.amplitude = AMP_W'(a);
        end
        r = $urandom_range(0, 9);
        if (r < 7)       x.bin_index = IDX_W'($urandom_range(0, NUM_BINS));
        else if (r == 7) x.bin_index = IDX_W'(NUM_BINS);
        else             x.bin_index = IDX_W'($urandom);
        return x;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(t_in x);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.absorb_beat(x);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.configure(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // drain all owed results, then let a non-closing sample finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pick_config(int p);
        logic [THR_W-1:0] t;
        logic [CH_W-1:0]  c;
        logic [CFG_W-1:0] r;
        logic [CFG_W-1:0] d;
        case (p % 4)
            0:       t = '0;
            1:       t = '1;
            default: t = THR_W'($urandom);
        endcase
        if (p == 5)      c = '0;
        else if (p == 7) c = CH_W'($urandom_range(9, 40));
        else             c = CH_W'($urandom_range(1, 8));
        case (p % 3)
            0:       r = CFG_W'($urandom_range(1, 40000));
            1:       r = CFG_W'($urandom);
            default: r = CFG_W'($urandom_range(1, 600));
        endcase
        if (p == 3) r = '1;
        if (p == 6) r = '0;
        // unused upper data bits carry noise
        d = CFG_W'($urandom);
        d[THR_W-1:0] = t;
        write_reg(CFG_THRESHOLD, d);
        d = CFG_W'($urandom);
        d[CH_W-1:0] = c;
        write_reg(CFG_CHANNELS, d);
        write_reg(CFG_RANGE_TOP, r);
        if (p == 0) write_reg(CFG_UNUSED, CFG_W'($urandom));
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_THRESHOLD;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_in           = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_seq  = 0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, reads first to see the cleared store
        set_mode(3);
        send_item(beat(OP_READ, '0, '0));
        send_item(beat(OP_READ, '0, IDX_W'(NUM_BINS)));
        repeat (30) send_item(random_beat());
        settle();

        // directed edge cases
        set_mode(0);
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_CHANNELS, CFG_W'(1));
        write_reg(CFG_RANGE_TOP, RANGE_TOP_RST);
        send_item(beat(OP_SAMPLE, '0, '0));
        send_item(beat(OP_SAMPLE, '1, '1));
        send_item(beat(OP_READ, '0, '0));
        send_item(beat(OP_READ, '0, IDX_W'(NUM_BINS)));
        send_item(beat(OP_READ, '0, IDX_W'(NUM_BINS + 1)));
        send_item(beat(OP_READ, '1, '1));
        send_item(beat(OP_READ, '0, IDX_W'(104)));
        settle();
        write_reg(CFG_RANGE_TOP, CFG_W'(1));
        send_item(beat(OP_SAMPLE, '0, '0));
        send_item(beat(OP_SAMPLE, AMP_W'(1), '0));
        settle();
        write_reg(CFG_RANGE_TOP, '0);
        send_item(beat(OP_SAMPLE, '0, '0));
        settle();
        write_reg(CFG_THRESHOLD, CFG_W'(AMP_MAX));
        send_item(beat(OP_SAMPLE, AMP_W'(AMP_MAX - 1), '0));
        send_item(beat(OP_SAMPLE, '1, '0));
        settle();
        write_reg(CFG_CHANNELS, '0);
        send_item(beat(OP_SAMPLE, AMP_W'(7), '0));
        settle();
        // channel count lowered with an event half done
        write_reg(CFG_THRESHOLD, '0);
        write_reg(CFG_CHANNELS, CFG_W'(4));
        send_item(beat(OP_SAMPLE, AMP_W'(10), '0));
        send_item(beat(OP_SAMPLE, AMP_W'(20), '0));
        settle();
        write_reg(CFG_CHANNELS, CFG_W'(2));
        send_item(beat(OP_SAMPLE, AMP_W'(30), '0));
        settle();
        // a read in the middle of an event leaves it alone
        write_reg(CFG_CHANNELS, CFG_W'(3));
        send_item(beat(OP_SAMPLE, AMP_W'(5), '0));
        send_item(beat(OP_READ, '0, IDX_W'(NUM_BINS)));
        send_item(beat(OP_SAMPLE, AMP_W'(6), '0));
        send_item(beat(OP_SAMPLE, AMP_W'(7), '0));
        settle();
        write_reg(CFG_RANGE_TOP, '1);
        write_reg(CFG_CHANNELS, CFG_W'(1));
        send_item(beat(OP_SAMPLE, '1, '0));
        send_item(beat(OP_READ, '0, IDX_W'(511)));
        settle();

        // one full-size event: channel count clamps, sum lands on range_top
        set_mode(1);
        write_reg(CFG_CHANNELS, CFG_W'((1 << CH_W) - 1));
        write_reg(CFG_RANGE_TOP, CFG_W'(MAX_CHANNELS * AMP_MAX));
        repeat (MAX_CHANNELS) send_item(beat(OP_SAMPLE, '1, IDX_W'($urandom)));
        send_item(beat(OP_READ, '0, IDX_W'(NUM_BINS)));
        settle();

        for (int p = 0; p < 8; p++) begin
            set_mode(p % 4);
            pick_config(p);
            if (p == 4) long_hold_seq++;
            repeat (PHASE_BEATS) send_item(random_beat());
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/eesh_pkg.sv
rtl/event_energy_sum_histogram.sv
verif/tb_event_energy_sum_histogram.sv
